@@ hdl/lbrc_pkg.sv @@
// lbrc_pkg: shared types and constants for the landmark bounding box unit
// no dependencies; imported by every module of the block

package lbrc_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int SCALE_FRAC_BITS_DEF = 14;
  localparam int QUEUE_DEPTH_DEF     = 4;

  localparam int FRAME_W    = 15;
  localparam int SCALE_W    = 16;
  localparam int BOX_W      = 18;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 4 * BOX_W;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_LEFT   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_TOP    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_RIGHT  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_BOTTOM = 3'd5;

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 15'd1920;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 15'd1080;
  localparam logic [SCALE_W-1:0] SCALE_LEFT_RST   = 16'd31548;
  localparam logic [SCALE_W-1:0] SCALE_TOP_RST    = 16'd33736;
  localparam logic [SCALE_W-1:0] SCALE_RIGHT_RST  = 16'd31548;
  localparam logic [SCALE_W-1:0] SCALE_BOTTOM_RST = 16'd26357;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
    logic [SCALE_W-1:0] scale_left;
    logic [SCALE_W-1:0] scale_top;
    logic [SCALE_W-1:0] scale_right;
    logic [SCALE_W-1:0] scale_bottom;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic full;
  } queue_ctl_t;

endpackage

@@ hdl/landmark_bbox_rescale_clamp_unit.sv @@
// landmark_bbox_rescale_clamp_unit: top level with configuration registers
// depends on lbrc_pkg, lbrc_front, lbrc_queue, lbrc_back

// Landmark points stream in one per cycle on the slave side, tlast marking the
// last point of a face; each face yields one rectangle (x, y, width, height) on
// the master side. The input side takes one point every cycle as long as the
// extent queue (QUEUE_DEPTH faces) has room. The box pipeline (centre, scaled size,
// edge, rounding and output registers) moves one face per cycle and stalls as a
// whole only while its output register waits on m_axis_tready. Registers are to be
// written via cfg_we_i/cfg_addr_i/cfg_wdata_i while idle; the block does not check.

module landmark_bbox_rescale_clamp_unit #(
  parameter int COORD_BITS      = lbrc_pkg::COORD_BITS_DEF,
  parameter int SCALE_FRAC_BITS = lbrc_pkg::SCALE_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH     = lbrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // point_x, point_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                   s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // box_x, box_y, box_width, box_height
  output logic [lbrc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  input  logic                                   cfg_we_i,
  input  logic [lbrc_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [lbrc_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);
  import lbrc_pkg::*;

  localparam int EXT_W = 4 * COORD_BITS;

  cfg_t             cfg_q, cfg_d;
  queue_ctl_t       qctl;
  logic             q_full, q_empty, q_pop;
  logic [EXT_W-1:0] ext_wdata, ext_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_wdata_i[FRAME_W-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height = cfg_wdata_i[FRAME_W-1:0];
        REG_SCALE_LEFT:   cfg_d.scale_left   = cfg_wdata_i[SCALE_W-1:0];
        REG_SCALE_TOP:    cfg_d.scale_top    = cfg_wdata_i[SCALE_W-1:0];
        REG_SCALE_RIGHT:  cfg_d.scale_right  = cfg_wdata_i[SCALE_W-1:0];
        REG_SCALE_BOTTOM: cfg_d.scale_bottom = cfg_wdata_i[SCALE_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= FRAME_WIDTH_RST;
      cfg_q.frame_height <= FRAME_HEIGHT_RST;
      cfg_q.scale_left   <= SCALE_LEFT_RST;
      cfg_q.scale_top    <= SCALE_TOP_RST;
      cfg_q.scale_right  <= SCALE_RIGHT_RST;
      cfg_q.scale_bottom <= SCALE_BOTTOM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lbrc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .point_x_i    (s_axis_tdata[COORD_BITS-1:0]),
    .point_y_i    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .last_point_i (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .queue_full_i (q_full),
    .qctl_o       (qctl),
    .extent_o     (ext_wdata)
  );

  lbrc_queue #(
    .WIDTH (EXT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qctl_i  (qctl),
    .wdata_i (ext_wdata),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .rdata_o (ext_rdata)
  );

  lbrc_back #(
    .COORD_BITS      (COORD_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (ext_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

@@ hdl/lbrc_front.sv @@
// lbrc_front: accepts landmark points and tracks the running min and max per face
// depends on lbrc_pkg; hands finished extents to lbrc_queue

module lbrc_front #(
  parameter int COORD_BITS = lbrc_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [COORD_BITS-1:0]   point_x_i,
  input  logic [COORD_BITS-1:0]   point_y_i,
  input  logic                    last_point_i,
  output logic                    in_ready_o,
  input  logic                    queue_full_i,
  output lbrc_pkg::queue_ctl_t    qctl_o,
  output logic [4*COORD_BITS-1:0] extent_o   // min_x, max_x, min_y, max_y
);
  import lbrc_pkg::*;

  logic signed [COORD_BITS-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [COORD_BITS-1:0] min_x_d, max_x_d, min_y_d, max_y_d;
  logic signed [COORD_BITS-1:0] px, py;
  logic                         first_q, first_d;
  logic                         accept;

  assign px         = $signed(point_x_i);
  assign py         = $signed(point_y_i);
  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    if (first_q) begin
      min_x_d = px;
      max_x_d = px;
      min_y_d = py;
      max_y_d = py;
    end else begin
      min_x_d = (px < min_x_q) ? px : min_x_q;
      max_x_d = (px > max_x_q) ? px : max_x_q;
      min_y_d = (py < min_y_q) ? py : min_y_q;
      max_y_d = (py > max_y_q) ? py : max_y_q;
    end
    first_d = first_q;
    if (accept) begin
      first_d = last_point_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else begin
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
    end
  end

  assign qctl_o.push = accept & last_point_i;
  assign qctl_o.full = queue_full_i;
  assign extent_o    = {max_y_d, min_y_d, max_x_d, min_x_d};

endmodule

@@ hdl/lbrc_queue.sv @@
// lbrc_queue: short fifo of face extents between tracker and box pipeline
// depends on lbrc_pkg

module lbrc_queue #(
  parameter int WIDTH = 4 * lbrc_pkg::COORD_BITS_DEF,
  parameter int DEPTH = lbrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbrc_pkg::queue_ctl_t qctl_i,
  input  logic [WIDTH-1:0]     wdata_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     rdata_o
);
  import lbrc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push    = qctl_i.push & ~full_o;
  assign pop     = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qctl_i.push && qctl_i.full && !full_o))
    else $error("queue full flag out of step with front");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qctl_i.push && full_o && !pop))
    else $error("extent pushed into full queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

@@ hdl/lbrc_back.sv @@
// lbrc_back: pipeline from face extent to clamped, normalized rectangle
// depends on lbrc_pkg; fed by lbrc_queue, drives the output register

module lbrc_back #(
  parameter int COORD_BITS      = lbrc_pkg::COORD_BITS_DEF,
  parameter int SCALE_FRAC_BITS = lbrc_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lbrc_pkg::cfg_t                  cfg_i,
  input  logic                            q_empty_i,
  input  logic [4*COORD_BITS-1:0]         q_data_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lbrc_pkg::OUT_DATA_W-1:0] out_data_o
);
  import lbrc_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int F    = SCALE_FRAC_BITS;
  localparam int PW   = SCALE_W + C - 1;
  localparam int S    = ((C + F > PW + 1) ? C + F : PW + 1) + 2;
  localparam int EW   = (S - F + 2 > BOX_W) ? S - F + 2 : BOX_W;
  localparam logic [S:0] HALF = (S + 1)'(1) << (F - 1);

  function automatic logic signed [EW-1:0] round_q(input logic signed [S-1:0] v);
    logic [S-1:0]  mag;
    logic [S:0]    q;
    logic [EW-1:0] qe;
    mag = v[S-1] ? S'(-v) : S'(v);
    q   = ({1'b0, mag} + HALF) >> F;
    qe  = EW'(q);
    return v[S-1] ? $signed(-qe) : $signed(qe);
  endfunction

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;

  // stage 1: centre and half size
  logic signed [C-1:0] mnx, mxx, mny, mxy;
  logic signed [C:0]   sx, sy, sxa, sya, wx, wy;
  logic [C-1:0]        tm;
  logic signed [C-1:0] cx_q, cy_q;
  logic [C-2:0]        t_q;

  assign mnx = $signed(q_data_i[C-1:0]);
  assign mxx = $signed(q_data_i[2*C-1:C]);
  assign mny = $signed(q_data_i[3*C-1:2*C]);
  assign mxy = $signed(q_data_i[4*C-1:3*C]);

  always_comb begin
    sx  = {mnx[C-1], mnx} + {mxx[C-1], mxx};
    sy  = {mny[C-1], mny} + {mxy[C-1], mxy};
    sxa = sx + $signed({{C{1'b0}}, sx[C]});
    sya = sy + $signed({{C{1'b0}}, sy[C]});
    wx  = {mxx[C-1], mxx} - {mnx[C-1], mnx};
    wy  = {mxy[C-1], mxy} - {mny[C-1], mny};
    tm  = (wx[C-1:0] > wy[C-1:0]) ? wx[C-1:0] : wy[C-1:0];
  end

  // stage 2: scaled half sizes
  logic [PW-1:0]       pl_q, pt_q, pr_q, pb_q;
  logic signed [C-1:0] cx2_q, cy2_q;

  // stage 3: unrounded edges
  logic signed [S-1:0] cxs, cys;
  logic signed [S-1:0] el_q, et_q, er_q, eb_q;

  assign cxs = $signed({{(S-C-F){cx2_q[C-1]}}, cx2_q, {F{1'b0}}});
  assign cys = $signed({{(S-C-F){cy2_q[C-1]}}, cy2_q, {F{1'b0}}});

  // stage 4: rounded edges
  logic signed [EW-1:0] l_q, tp_q, r_q, b_q;

  // stage 5: clamp and normalize
  logic signed [EW-1:0] lc, tc, rc, bc, bx, by, fw, fh;
  logic signed [EW:0]   dx, dy;
  logic [EW:0]          bw, bh;
  logic [OUT_DATA_W-1:0] out_data_q;

  always_comb begin
    fw = $signed({{(EW-FRAME_W){1'b0}}, cfg_i.frame_width});
    fh = $signed({{(EW-FRAME_W){1'b0}}, cfg_i.frame_height});
    lc = l_q[EW-1]  ? '0 : l_q;
    tc = tp_q[EW-1] ? '0 : tp_q;
    rc = (r_q > fw) ? fw : r_q;
    bc = (b_q > fh) ? fh : b_q;
    bx = (lc < rc) ? lc : rc;
    by = (tc < bc) ? tc : bc;
    dx = {rc[EW-1], rc} - {lc[EW-1], lc};
    dy = {bc[EW-1], bc} - {tc[EW-1], tc};
    bw = dx[EW] ? (EW+1)'(-dx) : (EW+1)'(dx);
    bh = dy[EW] ? (EW+1)'(-dy) : (EW+1)'(dy);
  end

  assign en      = ~out_valid_q | out_ready_i;
  assign q_pop_o = en & ~q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= ~q_empty_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q  <= sxa[C:1];
      cy_q  <= sya[C:1];
      t_q   <= tm[C-1:1];
      pl_q  <= PW'(cfg_i.scale_left)   * PW'(t_q);
      pt_q  <= PW'(cfg_i.scale_top)    * PW'(t_q);
      pr_q  <= PW'(cfg_i.scale_right)  * PW'(t_q);
      pb_q  <= PW'(cfg_i.scale_bottom) * PW'(t_q);
      cx2_q <= cx_q;
      cy2_q <= cy_q;
      el_q  <= cxs - $signed({{(S-PW){1'b0}}, pl_q});
      et_q  <= cys - $signed({{(S-PW){1'b0}}, pt_q});
      er_q  <= cxs + $signed({{(S-PW){1'b0}}, pr_q});
      eb_q  <= cys + $signed({{(S-PW){1'b0}}, pb_q});
      l_q   <= round_q(el_q);
      tp_q  <= round_q(et_q);
      r_q   <= round_q(er_q);
      b_q   <= round_q(eb_q);
      out_data_q <= {bh[BOX_W-1:0], bw[BOX_W-1:0], by[BOX_W-1:0], bx[BOX_W-1:0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(v4_q) && $stable(v1_q)))
    else $error("pipeline advanced while output stalled");

  a_pop_only_when_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> en)
    else $error("queue popped while pipeline stalled");

  a_pop_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> v1_q)
    else $error("popped extent lost before first stage");

endmodule

@@ tb/sv/lbrc_box_checker.sv @@
`timescale 1ns / 1ps
// lbrc_box_checker: watches the point, box and register channels of the landmark box unit,
// predicts each face rectangle and compares it with the box transfers that come out
// depends on lbrc_pkg for the register map, field widths and reset values

module lbrc_box_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // point_x, point_y
  input  logic [31:0]                         s_axis_tdata,
  input  logic                                s_axis_tlast,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // box_x, box_y, box_width, box_height
  input  logic [lbrc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [lbrc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [lbrc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output int                                  mismatch_count_o,
  output int                                  boxes_pending_o
);

  import lbrc_pkg::*;

  localparam int COORD = COORD_BITS_DEF;
  localparam int FRAC  = SCALE_FRAC_BITS_DEF;

  typedef struct packed {
    logic [BOX_W-1:0] height;
    logic [BOX_W-1:0] width;
    logic [BOX_W-1:0] y;
    logic [BOX_W-1:0] x;
  } box_t;

  cfg_t   regs;
  longint lo_x, hi_x, lo_y, hi_y;
  bit     new_face;
  box_t   box_q[$];
  int     mismatches = 0;

  assign mismatch_count_o = mismatches;

  // centre moved by scale * half size, rounded half away from zero
  function automatic longint box_edge(input longint ctr, input longint scale,
                                      input longint half, input bit plus);
    longint q;
    longint rnd;
    rnd = longint'(1) <<< (FRAC - 1);
    q = ctr * (longint'(1) <<< FRAC);
    q = plus ? q + scale * half : q - scale * half;
    if (q >= 0) return (q + rnd) >>> FRAC;
    return -((-q + rnd) >>> FRAC);
  endfunction

  function automatic box_t close_face();
    longint w, h, cx, cy, t, l, tp, r, b, fw, fh;
    box_t   bx;
    w  = hi_x - lo_x;
    h  = hi_y - lo_y;
    cx = (lo_x + hi_x) / 2;
    cy = (lo_y + hi_y) / 2;
    t  = ((w > h) ? w : h) / 2;
    fw = longint'(regs.frame_width);
    fh = longint'(regs.frame_height);
    l  = box_edge(cx, longint'(regs.scale_left), t, 1'b0);
    tp = box_edge(cy, longint'(regs.scale_top), t, 1'b0);
    r  = box_edge(cx, longint'(regs.scale_right), t, 1'b1);
    b  = box_edge(cy, longint'(regs.scale_bottom), t, 1'b1);
    if (l < 0) l = 0;
    if (r > fw) r = fw;
    if (tp < 0) tp = 0;
    if (b > fh) b = fh;
    w = (l < r) ? l : r;
    h = (tp < b) ? tp : b;
    bx.x = w[BOX_W-1:0];
    bx.y = h[BOX_W-1:0];
    w = (r > l) ? r - l : l - r;
    h = (b > tp) ? b - tp : tp - b;
    bx.width  = w[BOX_W-1:0];
    bx.height = h[BOX_W-1:0];
    return bx;
  endfunction

  task automatic check_field(input string name, input logic [BOX_W-1:0] want,
                             input logic [BOX_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: box %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    longint px, py;
    box_t   want, got;
    if (!rst_ni) begin
      regs.frame_width  = FRAME_WIDTH_RST;
      regs.frame_height = FRAME_HEIGHT_RST;
      regs.scale_left   = SCALE_LEFT_RST;
      regs.scale_top    = SCALE_TOP_RST;
      regs.scale_right  = SCALE_RIGHT_RST;
      regs.scale_bottom = SCALE_BOTTOM_RST;
      lo_x = 0;
      hi_x = 0;
      lo_y = 0;
      hi_y = 0;
      new_face = 1'b1;
      box_q.delete();
      boxes_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_FRAME_WIDTH:  regs.frame_width  = cfg_wdata_i[FRAME_W-1:0];
          REG_FRAME_HEIGHT: regs.frame_height = cfg_wdata_i[FRAME_W-1:0];
          REG_SCALE_LEFT:   regs.scale_left   = cfg_wdata_i[SCALE_W-1:0];
          REG_SCALE_TOP:    regs.scale_top    = cfg_wdata_i[SCALE_W-1:0];
          REG_SCALE_RIGHT:  regs.scale_right  = cfg_wdata_i[SCALE_W-1:0];
          REG_SCALE_BOTTOM: regs.scale_bottom = cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        px = $signed(s_axis_tdata[COORD-1:0]);
        py = $signed(s_axis_tdata[2*COORD-1:COORD]);
        if (new_face) begin
          lo_x = px;
          hi_x = px;
          lo_y = py;
          hi_y = py;
          new_face = 1'b0;
        end else begin
          if (px < lo_x) lo_x = px;
          if (px > hi_x) hi_x = px;
          if (py < lo_y) lo_y = py;
          if (py > hi_y) hi_y = py;
        end
        if (s_axis_tlast) begin
          box_q.insert(box_q.size(), close_face());
          new_face = 1'b1;
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (box_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected box transfer, expected none, actual %h", $time, got);
        end else begin
          want = box_q.pop_front();
          check_field("x", want.x, got.x);
          check_field("y", want.y, got.y);
          check_field("width", want.width, got.width);
          check_field("height", want.height, got.height);
        end
      end

      boxes_pending_o <= box_q.size();
    end
  end

endmodule

@@ tb/sv/tb_landmark_bbox_rescale_clamp_unit.sv @@
`timescale 1ns / 1ps
// tb_landmark_bbox_rescale_clamp_unit: drives landmark faces and register settings into
// the landmark box unit; lbrc_box_checker predicts and compares the rectangles
// depends on lbrc_pkg, landmark_bbox_rescale_clamp_unit and lbrc_box_checker

module tb_landmark_bbox_rescale_clamp_unit;

  import lbrc_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int PHASES        = 8;
  localparam int PHASE_POINTS  = 100;
  localparam int SETTLE_CYCLES = 12;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [31:0]             s_axis_tdata  = '0;
  logic                    s_axis_tlast  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i   = '0;
  int                      mismatch_count;
  int                      boxes_pending;

  int points_sent = 0;
  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  landmark_bbox_rescale_clamp_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  lbrc_box_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatch_count),
    .boxes_pending_o  (boxes_pending)
  );

  task automatic send_point(input logic [15:0] x, input logic [15:0] y, input bit last);
    int gap;
    if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    points_sent++;
  endtask

  // spread < 0 draws every point over the whole coordinate range
  task automatic send_face(input int count, input int spread);
    int cx, cy, i;
    logic [15:0] x, y;
    cx = int'($urandom_range(0, 8000)) - 3000;
    cy = int'($urandom_range(0, 6000)) - 2000;
    for (i = 0; i < count; i++) begin
      if (spread < 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = 16'(cx + int'($urandom_range(0, spread)) - spread / 2);
        y = 16'(cy + int'($urandom_range(0, spread)) - spread / 2);
      end
      send_point(x, y, i == count - 1);
    end
  endtask

  // wait out the last box and whatever is still inside the pipeline
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (boxes_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [15:0] fw, input logic [15:0] fh,
                             input logic [15:0] sl, input logic [15:0] st,
                             input logic [15:0] sr, input logic [15:0] sb);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_SCALE_LEFT, sl);
    write_reg(REG_SCALE_TOP, st);
    write_reg(REG_SCALE_RIGHT, sr);
    write_reg(REG_SCALE_BOTTOM, sb);
    // unmapped indexes must leave every register alone
    write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // result side: random stalls per box with stretches of steady ready
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int p, r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed faces at the reset settings
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'h8000, 16'h8000, 1'b1);
    send_point(16'h7fff, 16'h7fff, 1'b1);
    send_point(16'h8000, 16'h7fff, 1'b1);
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h7fff, 16'h7fff, 1'b1);
    send_point(16'sd100, 16'sd200, 1'b0);
    send_point(-16'sd3, 16'sd150, 1'b0);
    send_point(16'sd40, -16'sd9, 1'b1);
    send_point(-16'sd101, -16'sd7, 1'b0);
    send_point(-16'sd90, 16'sd3, 1'b1);
    send_point(16'sd960, 16'sd540, 1'b0);
    send_point(16'sd1000, 16'sd600, 1'b1);
    send_point(-16'sd5000, -16'sd4000, 1'b0);
    send_point(-16'sd4000, -16'sd5000, 1'b0);
    send_point(-16'sd4500, -16'sd4500, 1'b1);
    send_point(16'sd1900, 16'sd1070, 1'b0);
    send_point(16'sd1950, 16'sd1100, 1'b1);
    send_point(16'sd3, 16'sd5, 1'b0);
    send_point(16'sd4, 16'sd8, 1'b1);
    send_point(16'sd5000, -16'sd30, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        settle();
        case (p)
          1: load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
          2: load_config(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
          3: load_config(16'h7fff, 16'h7fff, 16'h4000, 16'h4000, 16'h4000, 16'h4000);
          7: load_config(16'(FRAME_WIDTH_RST), 16'(FRAME_HEIGHT_RST), SCALE_LEFT_RST,
                         SCALE_TOP_RST, SCALE_RIGHT_RST, SCALE_BOTTOM_RST);
          default: load_config(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 4000)),
                               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        endcase
      end
      r = points_sent + PHASE_POINTS;
      while (points_sent < r) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_face($urandom_range(1, 8), $urandom_range(0, 400));
          6, 7:             send_face($urandom_range(5, 68), $urandom_range(0, 3000));
          8:                send_face($urandom_range(1, 6), -1);
          default:          send_face(1, 0);
        endcase
      end
    end

    settle();
    if (mismatch_count == 0 && boxes_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
